>>> hw/rtl/hdt_pkg.sv
// Package for the hash de-duplication table.
// Holds sizing constants, operation codes, the sequencer state type and
// the memory request struct. No dependencies.
package hdt_pkg;

  localparam int CAPACITY  = 1024;
  localparam int HASH_W    = 64;
  localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 11;

  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [HASH_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> hw/rtl/hdt_in_if.sv
// Request channel of the hash de-duplication table.
// Carries valid, ready, func and hash_value. Depends on hdt_pkg.
interface hdt_in_if;
  import hdt_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [HASH_W-1:0] hash_value;

  modport source (output valid, output func, output hash_value, input ready);
  modport sink   (input valid, input func, input hash_value, output ready);
endinterface

>>> hw/rtl/hdt_out_if.sv
// Result channel of the hash de-duplication table.
// Carries valid, ready and the result flags and count. Depends on hdt_pkg.
interface hdt_out_if;
  import hdt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 already_seen;
  logic                 newly_added;
  logic                 table_full;
  logic [OUT_CNT_W-1:0] entries_held;

  modport source (output valid, output already_seen, output newly_added,
                  output table_full, output entries_held, input ready);
  modport sink   (input valid, input already_seen, input newly_added,
                  input table_full, input entries_held, output ready);
endinterface

>>> hw/rtl/hdt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Width and depth are parameters. No dependencies.
module hdt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/hdt_ctrl.sv
// Scan sequencer of the hash de-duplication table: request capture, the
// shared hash comparator, entry count and result register.
// Depends on hdt_pkg, hdt_in_if and hdt_out_if; drives the hash RAM.
module hdt_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  hdt_in_if.sink                   in_ch,
  hdt_out_if.source                out_ch,
  output hdt_pkg::mem_req_t        mem_req,
  input  logic [hdt_pkg::HASH_W-1:0] rd_data
);
  import hdt_pkg::*;

  state_t               state_r, state_nxt;
  logic                 func_r, func_nxt;
  logic [HASH_W-1:0]    hash_r, hash_nxt;
  logic                 seen_r, seen_nxt;
  logic                 pend_r, pend_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 ovld_r, ovld_nxt;
  logic                 oseen_r, oseen_nxt;
  logic                 oadd_r, oadd_nxt;
  logic                 ofull_r, ofull_nxt;
  logic [OUT_CNT_W-1:0] ocnt_r, ocnt_nxt;

  logic match;
  logic scan_end;
  logic has_room;
  logic fin_ok;
  logic add;

  assign match    = pend_r && (rd_data == hash_r);
  assign scan_end = (idx_r == count_r);
  assign has_room = (count_r < CNT_W'(CAPACITY));
  assign fin_ok   = !ovld_r || out_ch.ready;
  assign add      = (func_r == FUNC_CHECK) && !seen_r && has_room;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (in_ch.func == FUNC_CLEAR) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match || scan_end) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    mem_req     = '0;
    func_nxt    = func_r;
    hash_nxt    = hash_r;
    seen_nxt    = seen_r;
    pend_nxt    = 1'b0;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    ovld_nxt    = ovld_r && !out_ch.ready;
    oseen_nxt   = oseen_r;
    oadd_nxt    = oadd_r;
    ofull_nxt   = ofull_r;
    ocnt_nxt    = ocnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          func_nxt = in_ch.func;
          hash_nxt = in_ch.hash_value;
          seen_nxt = 1'b0;
          idx_nxt  = '0;
        end
      end
      ST_SCAN: begin
        if (match) begin
          seen_nxt = 1'b1;
        end else if (!scan_end) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_r[ADDR_W-1:0];
          idx_nxt       = idx_r + 1'b1;
          pend_nxt      = 1'b1;
        end
      end
      ST_FINISH: begin
        if (fin_ok) begin
          if (func_r == FUNC_CLEAR) begin
            count_nxt = '0;
          end else if (add) begin
            count_nxt = count_r + 1'b1;
          end
          mem_req.we    = add;
          mem_req.waddr = count_r[ADDR_W-1:0];
          mem_req.wdata = hash_r;
          ovld_nxt      = 1'b1;
          oseen_nxt     = (func_r == FUNC_CHECK) && seen_r;
          oadd_nxt      = add;
          ofull_nxt     = (func_r == FUNC_CHECK) && !seen_r && !has_room;
          ocnt_nxt      = OUT_CNT_W'(count_nxt);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      count_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      count_r <= count_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    hash_r  <= hash_nxt;
    seen_r  <= seen_nxt;
    idx_r   <= idx_nxt;
    oseen_r <= oseen_nxt;
    oadd_r  <= oadd_nxt;
    ofull_r <= ofull_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  assign out_ch.valid        = ovld_r;
  assign out_ch.already_seen = oseen_r;
  assign out_ch.newly_added  = oadd_r;
  assign out_ch.table_full   = ofull_r;
  assign out_ch.entries_held = ocnt_r;

endmodule

>>> hw/rtl/hash_dedup_table.sv
// Top level of the hash de-duplication table: scan sequencer plus hash RAM.
// Depends on hdt_pkg, hdt_in_if, hdt_out_if, hdt_ram and hdt_ctrl.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        func, hash_value
//   out_ch   out  valid/ready        already_seen, newly_added, table_full,
//                                    entries_held
//
// A check scans the stored hashes through one RAM read port and one 64-bit
// comparator, comparing entries in order up to the entry count and stopping at
// the first match. A clear skips the scan. Input ready is high only while idle;
// a pending result stalls the finish state until out_ch is free. Reset clears the
// entry count, the state and the output valid, with no RAM pass.
module hash_dedup_table (
  input  logic      clk,
  input  logic      rst_n,
  hdt_in_if.sink    in_ch,
  hdt_out_if.source out_ch
);
  import hdt_pkg::*;

  mem_req_t          mem_req;
  logic [HASH_W-1:0] rd_data;

  hdt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  hdt_ram #(
    .WIDTH (HASH_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

endmodule
